// File: design/scmp_pkg.sv
package scmp_pkg;

  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned CODE_W   = 8;
  localparam int unsigned STEPS    = 8;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 12'd4095;
  localparam logic [CODE_W-1:0]   CODE_MAX   = 8'd255;
  localparam logic [CODE_W-1:0]   LINEAR_TOP = 8'd64;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [CODE_W-1:0]   code_t;

  // search window carried from cell to cell
  typedef struct packed {
    sample_t sample;
    logic    last;
    code_t   low;
    code_t   high;
  } stage_t;

  // expansion table: linear up to 63, then six 32-entry segments, step 2..64
  function automatic sample_t rom_entry(input code_t c);
    logic [2:0]  seg;
    logic [5:0]  ofs;
    logic [12:0] base;
    logic [12:0] step;
    if (c < LINEAR_TOP) begin
      return {4'd0, c};
    end
    seg  = 3'((c - LINEAR_TOP) >> 5);
    ofs  = {1'b0, c[4:0]} + 6'd1;
    base = (13'd64 << seg) - 13'd1;
    step = {7'd0, ofs} << (seg + 3'd1);
    return 12'(base + step);
  endfunction

endpackage

// File: design/scmp_in_if.sv
interface scmp_in_if;
  import scmp_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;
  logic    last_in;

  modport source (output valid, output sample, output last_in, input ready);
  modport sink (input valid, input sample, input last_in, output ready);
endinterface

// File: design/scmp_out_if.sv
interface scmp_out_if;
  import scmp_pkg::*;

  logic  valid;
  logic  ready;
  code_t code;
  logic  last_out;

  modport source (output valid, output code, output last_out, input ready);
  modport sink (input valid, input code, input last_out, output ready);
endinterface

// File: design/scmp_cell.sv
module scmp_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  scmp_pkg::stage_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output scmp_pkg::stage_t out_data
);
  import scmp_pkg::*;

  logic    valid;
  stage_t  data;
  stage_t  data_next;
  logic [8:0] mid_sum;
  code_t   mid;
  sample_t v;
  sample_t vn;
  sample_t vp;
  logic    hit;

  assign mid_sum = {1'b0, in_data.low} + {1'b0, in_data.high} + 9'd1;
  assign mid     = mid_sum[8:1];
  assign v       = rom_entry(mid);
  assign vn      = rom_entry(mid + 8'd1);
  assign vp      = rom_entry(mid - 8'd1);

  assign hit = (in_data.sample >= v && mid != CODE_MAX && in_data.sample < vn) ||
               (in_data.sample <= v && in_data.sample > vp);

  always_comb begin
    data_next = in_data;
    if (in_data.low < in_data.high) begin
      if (hit) begin
        data_next.low  = mid;
        data_next.high = mid;
      end else if (v > in_data.sample) begin
        data_next.high = mid - 8'd1;
      end else begin
        data_next.low = mid;
      end
    end
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;
endmodule

// File: design/sample_compander_12_to_8.sv
// 12-bit to 8-bit sample compander.
// samples (sink): one linear 12-bit sample per item plus a last mark.
// codes (source): one 8-bit companded code per item, last mark copied.
// Both channels move an item when valid and ready are high at a clock edge.
// The code is found by an eight-step binary search over the expansion table;
// each step is one cell of an eight-cell chain. An item accepted into the
// first cell moves through the cell registers in order and is presented on
// codes from the last cell; one item enters per cycle unless the chain is full.
// Zero and full scale are settled at entry and ride the chain unchanged.
// Each cell holds one item and takes a new one whenever it is empty or its
// item moves on, so a stalled receiver fills the chain back to front and
// samples.ready drops only once all eight cells hold items.
// Synchronous reset empties the chain; there is no other state.
module sample_compander_12_to_8 (
  input logic        clk,
  input logic        rst,
  scmp_in_if.sink    samples,
  scmp_out_if.source codes
);
  import scmp_pkg::*;

  logic   stage_valid [0:STEPS];
  logic   stage_ready [0:STEPS];
  stage_t stage_data  [0:STEPS];

  always_comb begin
    stage_data[0].sample = samples.sample;
    stage_data[0].last   = samples.last_in;
    if (samples.sample == '0) begin
      stage_data[0].low  = '0;
      stage_data[0].high = '0;
    end else if (samples.sample >= SAMPLE_MAX) begin
      stage_data[0].low  = CODE_MAX;
      stage_data[0].high = CODE_MAX;
    end else begin
      stage_data[0].low  = '0;
      stage_data[0].high = CODE_MAX;
    end
  end

  assign stage_valid[0] = samples.valid;
  assign samples.ready  = stage_ready[0];

  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    scmp_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stage_valid[i]),
      .in_ready  (stage_ready[i]),
      .in_data   (stage_data[i]),
      .out_valid (stage_valid[i+1]),
      .out_ready (stage_ready[i+1]),
      .out_data  (stage_data[i+1])
    );
  end

  assign codes.valid        = stage_valid[STEPS];
  assign stage_ready[STEPS] = codes.ready;
  assign codes.code         = stage_data[STEPS].low;
  assign codes.last_out     = stage_data[STEPS].last;

  for (genvar i = 1; i <= STEPS; i++) begin : g_chk
    assert property (@(posedge clk) disable iff (rst)
      stage_valid[i] |-> stage_data[i].low <= stage_data[i].high)
      else $error("search window inverted");
  end

  assert property (@(posedge clk) disable iff (rst)
    codes.valid |-> stage_data[STEPS].low == stage_data[STEPS].high)
    else $error("search not converged at output");

  assert property (@(posedge clk) disable iff (rst)
    codes.valid |->
      (codes.code == CODE_MAX ||
       stage_data[STEPS].sample < rom_entry(codes.code + 8'd1)) &&
      (codes.code == '0 ||
       rom_entry(codes.code - 8'd1) < stage_data[STEPS].sample))
    else $error("code does not bracket sample");

  assert property (@(posedge clk) disable iff (rst)
    stage_valid[1] && !stage_ready[1] |=> $stable(stage_data[1]))
    else $error("first cell lost its item under stall");
endmodule
